// ===== hw/rtl/pgb_pkg.sv =====
// Shared constants, codes and types of the proportional glyph blitter.
`default_nettype none

package pgb_pkg;

  localparam int SCREEN_WIDTH_DEF     = 640;
  localparam int ROW_BYTES_DEF        = 80;
  localparam int FONT_STORE_BYTES_DEF = 4096;
  localparam int GLYPH_ROWS_DEF       = 16;

  localparam logic [7:0] CODE_END      = 8'h00;
  localparam logic [7:0] CODE_FIRST    = 8'h20;
  localparam logic [7:0] CODE_LAST     = 8'h7E;
  localparam logic [7:0] CODE_FALLBACK = 8'h3F;
  localparam logic [7:0] CODE_SPACE    = 8'h20;

  localparam int ADVANCE_BASE = 32;
  localparam int BITMAP_BASE  = 128;
  localparam int GLYPH_COUNT  = 95;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_VRAM_LINES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_PRESENT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] VRAM_LINES_RST = 11'd400;

  typedef enum logic [1:0] {
    FUNC_FONT  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_DRAW  = 2'd2
  } func_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [2:0] shift;
    logic [1:0] sel;
  } mask_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pgb_if.sv =====
// Valid/ready channel interfaces for command items and VRAM write items.
`default_nettype none

interface pgb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [11:0]        font_addr;
  logic [7:0]         font_byte;
  logic signed [15:0] start_left;
  logic signed [15:0] start_top;
  logic [3:0]         pen_colour;
  logic [15:0]        char_budget;
  logic [7:0]         char_code;

  modport source (
    output valid, func, font_addr, font_byte, start_left, start_top, pen_colour,
           char_budget, char_code,
    input  ready
  );
  modport sink (
    input  valid, func, font_addr, font_byte, start_left, start_top, pen_colour,
           char_budget, char_code,
    output ready
  );
endinterface

interface pgb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] vram_offset;
  logic [7:0]  vram_mask;
  logic [3:0]  write_colour;
  logic        last;

  modport source (
    output valid, vram_offset, vram_mask, write_colour, last,
    input  ready
  );
  modport sink (
    input  valid, vram_offset, vram_mask, write_colour, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/proportional_glyph_blitter_unit.sv =====
// Top level of the proportional glyph blitter: sequencer, font RAM and mask unit.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  in_ch    | sink      | valid/ready        | func, font bytes, string start, char code
//  out_ch   | source    | valid/ready        | vram_offset, vram_mask, write_colour, last
//  cfg_*    | sink      | cfg_we, no wait    | cfg_index, cfg_wdata
//
// Font writes, string starts and dropped or ended characters are handled in S_IDLE.
// A character not drawn (space, off screen) passes S_ADV only; a drawn one then runs
// S_LO, S_HI and n S_EMIT states per glyph row, n = 1..3 writes per row, as set by the
// single font RAM read port (two reads per row) and the one output register.
// A full output register stalls the sequencer; in_ch waits until the character is done.
// Reset is synchronous; the font RAM is not cleared and holds garbage until written.
`default_nettype none

module proportional_glyph_blitter_unit
  import pgb_pkg::*;
#(
  parameter int SCREEN_WIDTH     = SCREEN_WIDTH_DEF,
  parameter int ROW_BYTES        = ROW_BYTES_DEF,
  parameter int FONT_STORE_BYTES = FONT_STORE_BYTES_DEF,
  parameter int GLYPH_ROWS       = GLYPH_ROWS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  pgb_in_if.sink                     in_ch,
  pgb_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COLS   = SCREEN_WIDTH / 8;
  localparam int COL_W  = $clog2(COLS + 1);
  localparam int ROW_W  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int RAM_AW = $clog2(FONT_STORE_BYTES);
  localparam int MAX_RD = BITMAP_BASE + GLYPH_COUNT * 2 * GLYPH_ROWS;
  localparam int RD_AW  = $clog2(MAX_RD + 1);

  localparam logic [15:0]      ROW_STEP  = 16'(ROW_BYTES);
  localparam logic [15:0]      SCREEN_X  = 16'(SCREEN_WIDTH);
  localparam logic [ROW_W-1:0] ROW_FINAL = ROW_W'(GLYPH_ROWS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_LO,
    S_HI,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_off_r, out_off_nxt;
  logic [7:0]  out_mask_r, out_mask_nxt;
  logic [3:0]  out_colour_r, out_colour_nxt;
  logic        out_last_r, out_last_nxt;

  logic [CFG_DATA_W-1:0] vram_lines_r, vram_lines_nxt;
  logic                  font_present_r, font_present_nxt;

  logic        enabled_r, enabled_nxt;
  logic [15:0] cursor_r, cursor_nxt;
  logic [15:0] budget_r, budget_nxt;
  logic [3:0]  colour_r, colour_nxt;
  logic [15:0] top_off_r, top_off_nxt;

  logic [RD_AW-1:0] gbase_r, gbase_nxt;
  logic             space_r, space_nxt;
  logic [2:0]       shift_r, shift_nxt;
  logic [1:0]       nb_last_r, nb_last_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [15:0]      row_off_r, row_off_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic             rd_oor_r, rd_oor_nxt;

  logic              in_xfer;
  logic [7:0]        cc_c;
  logic [6:0]        idx_c;
  logic [RD_AW-1:0]  rd_addr;
  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic [7:0]        rdata_eff;
  logic signed [17:0] max_top_c;
  logic              draw_c;
  logic [COL_W-1:0]  col_c;
  logic              two_c;
  logic              three_c;
  logic [1:0]        nb_last_c;
  logic              emit_go;
  logic              row_last;
  logic              k_last;
  mask_req_t         mask_req;
  logic [7:0]        mask_c;

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vram_offset  = out_off_r;
  assign out_ch.vram_mask    = out_mask_r;
  assign out_ch.write_colour = out_colour_r;
  assign out_ch.last         = out_last_r;

  assign cc_c  = (in_ch.char_code < CODE_FIRST || in_ch.char_code > CODE_LAST) ?
                 CODE_FALLBACK : in_ch.char_code;
  assign idx_c = 7'(cc_c - CODE_FIRST);

  assign ram_we = in_xfer && (in_ch.func == FUNC_FONT) &&
                  (32'(in_ch.font_addr) < FONT_STORE_BYTES);

  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = RD_AW'(ADVANCE_BASE + 32'(idx_c));
      S_LO:    rd_addr = gbase_r + RD_AW'({row_r, 1'b1});
      S_EMIT:  rd_addr = gbase_r + RD_AW'((32'(row_r) + 32'd1) << 1);
      default: rd_addr = gbase_r;
    endcase
  end

  assign rd_oor_nxt = (32'(rd_addr) >= FONT_STORE_BYTES);
  assign rdata_eff  = rd_oor_r ? 8'h00 : ram_rdata;

  pgb_ram #(
    .WIDTH (8),
    .DEPTH (FONT_STORE_BYTES)
  ) u_font_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (RAM_AW'(in_ch.font_addr)),
    .wdata (in_ch.font_byte),
    .raddr (RAM_AW'(rd_addr)),
    .rdata (ram_rdata)
  );

  assign max_top_c = $signed(18'(vram_lines_r)) - $signed(18'(GLYPH_ROWS));

  assign draw_c    = !space_r && !cursor_r[15] && (cursor_r < SCREEN_X);
  assign col_c     = COL_W'(cursor_r[15:3]);
  assign two_c     = (32'(col_c) + 32'd1) < COLS;
  assign three_c   = (32'(col_c) + 32'd2) < COLS;
  assign nb_last_c = (cursor_r[2:0] == 3'd0) ? (two_c ? 2'd1 : 2'd0) :
                     (three_c ? 2'd2 : (two_c ? 2'd1 : 2'd0));

  assign emit_go  = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign row_last = (row_r == ROW_FINAL);
  assign k_last   = (k_r == nb_last_r);

  assign mask_req = '{lo: lo_r, hi: hi_r, shift: shift_r, sel: k_r};

  pgb_mask u_mask (
    .req  (mask_req),
    .mask (mask_c)
  );

  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_off_nxt      = out_off_r;
    out_mask_nxt     = out_mask_r;
    out_colour_nxt   = out_colour_r;
    out_last_nxt     = out_last_r;
    vram_lines_nxt   = vram_lines_r;
    font_present_nxt = font_present_r;
    enabled_nxt      = enabled_r;
    cursor_nxt       = cursor_r;
    budget_nxt       = budget_r;
    colour_nxt       = colour_r;
    top_off_nxt      = top_off_r;
    gbase_nxt        = gbase_r;
    space_nxt        = space_r;
    shift_nxt        = shift_r;
    nb_last_nxt      = nb_last_r;
    k_nxt            = k_r;
    row_nxt          = row_r;
    row_off_nxt      = row_off_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_VRAM_LINES:   vram_lines_nxt   = cfg_wdata;
        CFG_FONT_PRESENT: font_present_nxt = cfg_wdata[0];
        default:          vram_lines_nxt   = vram_lines_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_ch.func)
            FUNC_START: begin
              cursor_nxt  = $unsigned(in_ch.start_left);
              top_off_nxt = $unsigned(in_ch.start_top) * ROW_STEP;
              colour_nxt  = in_ch.pen_colour;
              budget_nxt  = in_ch.char_budget;
              enabled_nxt = font_present_r && !in_ch.start_top[15] &&
                            ($signed(18'(in_ch.start_top)) <= max_top_c);
            end
            FUNC_DRAW: begin
              if (enabled_r) begin
                if (in_ch.char_code == CODE_END || budget_r == 16'd0) begin
                  enabled_nxt = 1'b0;
                end else begin
                  budget_nxt = budget_r - 16'd1;
                  gbase_nxt  = RD_AW'(BITMAP_BASE + 32'(idx_c) * (2 * GLYPH_ROWS));
                  space_nxt  = (in_ch.char_code == CODE_SPACE);
                  state_nxt  = S_ADV;
                end
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADV: begin
        cursor_nxt = cursor_r + 16'(rdata_eff);
        if (draw_c) begin
          shift_nxt   = cursor_r[2:0];
          nb_last_nxt = nb_last_c;
          row_off_nxt = top_off_r + 16'(col_c);
          row_nxt     = '0;
          state_nxt   = S_LO;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LO: begin
        lo_nxt    = rdata_eff;
        state_nxt = S_HI;
      end
      S_HI: begin
        hi_nxt    = rdata_eff;
        k_nxt     = 2'd0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt  = 1'b1;
          out_off_nxt    = row_off_r + 16'(k_r);
          out_mask_nxt   = mask_c;
          out_colour_nxt = colour_r;
          out_last_nxt   = row_last && k_last;
          if (k_last) begin
            if (row_last) begin
              state_nxt = S_IDLE;
            end else begin
              row_nxt     = row_r + ROW_W'(1);
              row_off_nxt = row_off_r + ROW_STEP;
              state_nxt   = S_LO;
            end
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      vram_lines_r   <= VRAM_LINES_RST;
      font_present_r <= 1'b0;
      enabled_r      <= 1'b0;
      cursor_r       <= '0;
      budget_r       <= '0;
      colour_r       <= '0;
      top_off_r      <= '0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      vram_lines_r   <= vram_lines_nxt;
      font_present_r <= font_present_nxt;
      enabled_r      <= enabled_nxt;
      cursor_r       <= cursor_nxt;
      budget_r       <= budget_nxt;
      colour_r       <= colour_nxt;
      top_off_r      <= top_off_nxt;
    end
    out_off_r    <= out_off_nxt;
    out_mask_r   <= out_mask_nxt;
    out_colour_r <= out_colour_nxt;
    out_last_r   <= out_last_nxt;
    gbase_r      <= gbase_nxt;
    space_r      <= space_nxt;
    shift_r      <= shift_nxt;
    nb_last_r    <= nb_last_nxt;
    k_r          <= k_nxt;
    row_r        <= row_nxt;
    row_off_r    <= row_off_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    rd_oor_r     <= rd_oor_nxt;
  end

`ifndef SYNTHESIS
  a_emit_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("output loaded outside the emit state");

  a_last_ends_char: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("sequencer kept running after the final write of a character");

  a_byte_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (nb_last_r != 2'd3 && k_r <= nb_last_r))
    else $error("byte index beyond the writes of this row");

  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ADV && !(in_xfer && in_ch.func == FUNC_START)) |=> $stable(cursor_r))
    else $error("cursor moved outside string start and advance");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pgb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pgb_mask.sv =====
// Shared funnel shifter that cuts one glyph row into a shifted VRAM mask byte.
`default_nettype none

module pgb_mask
  import pgb_pkg::*;
(
  input  wire mask_req_t  req,
  output logic     [7:0]  mask
);

  logic [23:0] row_w;

  always_comb begin
    row_w = {req.lo, req.hi, 8'h00} >> req.shift;
    case (req.sel)
      2'd0:    mask = row_w[23:16];
      2'd1:    mask = row_w[15:8];
      2'd2:    mask = row_w[7:0];
      default: mask = 8'h00;
    endcase
  end

endmodule

`default_nettype wire
